[rtl/hcl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcl_pkg: shared types and constants
// Constants and types shared by the HSV plus tunable-white converter.
// ----------------------------------------------------------------------------
package hcl_pkg;

	localparam int HUE_W = 16;
	localparam int LVL_W = 8;
	localparam int KEL_W = 16;
	localparam int CFG_W = 15;
	localparam int IN_W  = 56;
	localparam int OUT_W = 40;
	localparam int SEC_W = 3;
	localparam int RNG_DW = 23;

	localparam logic [CFG_W-1:0] COLD_RST = 15'd6500;
	localparam logic [CFG_W-1:0] WARM_RST = 15'd2700;

	// configuration register indexes
	localparam logic CFG_COLD = 1'b0;
	localparam logic CFG_WARM = 1'b1;

	// 255 * 65536, the unit for q and t before scaling
	localparam logic [23:0] FULL_Q = 24'd16711680;
	// 255 * 255
	localparam logic [15:0] SAT_SQ = 16'd65025;
	localparam logic [7:0]  UNIT   = 8'd255;

	typedef enum logic [SEC_W-1:0] {
		SEC_RY = 3'd0,
		SEC_YG = 3'd1,
		SEC_GC = 3'd2,
		SEC_CB = 3'd3,
		SEC_BM = 3'd4,
		SEC_MR = 3'd5
	} sector_t;

	// width of one queued beat between front and back
	function automatic int pay_w(input int cb);
		return 6 * cb + 130;
	endfunction

endpackage

[rtl/hsv_cct_to_led_word.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_cct_to_led_word: HSV plus tunable white to packed LED word
// Top level: configuration registers, front stages, queue, back stages.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one pixel per beat (hue, saturation, brightness, white level,
//   white temperature); m_* returns one 40-bit LED word per pixel, in order.
//   cfg_* writes the cold (index 0) or warm (index 1) LED temperature; it is
//   always ready and is to be written only while no pixel is in flight; the
//   block does not enforce this.
// Throughput: one pixel per clock while m_tready is high.
// Pipeline: 2 front stages, the queue register, CHANNEL_BITS divider stages
//   and the output register; the first stage loads on the accepting edge.
//   The depth is set by the bit-per-stage restoring dividers.
// Reset: all stages and the queue empty, temperatures return to 6500 K cold
//   and 2700 K warm.
// Stall: while m_tvalid waits on a low m_tready the back half holds; the
//   front keeps taking pixels until the two-entry queue is full and a pixel
//   waits in its second stage, then drops s_tready.
// ----------------------------------------------------------------------------
module hsv_cct_to_led_word #(
	parameter int CHANNEL_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// hue[15:0] saturation[23:16] brightness[31:24] white_level[39:32]
	// white_kelvin[55:40]
	input  logic [hcl_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// led_word[39:0]
	output logic [hcl_pkg::OUT_W-1:0] m_tdata,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_index,
	input  logic [hcl_pkg::CFG_W-1:0] cfg_data
);

	localparam int PAY = hcl_pkg::pay_w(CHANNEL_BITS);

	logic [hcl_pkg::CFG_W-1:0] cold_q, warm_q;
	logic           push, full, pop, empty;
	logic [PAY-1:0] pay_in, pay_out;

	assign cfg_ready = 1'b1;

	// write temperature registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cold_q <= hcl_pkg::COLD_RST;
			warm_q <= hcl_pkg::WARM_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				hcl_pkg::CFG_COLD: cold_q <= cfg_data;
				hcl_pkg::CFG_WARM: warm_q <= cfg_data;
			endcase
		end
	end

	hcl_front #(.CB(CHANNEL_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cold_kelvin (cold_q),
		.warm_kelvin (warm_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_data     (s_tdata),
		.push        (push),
		.pay         (pay_in),
		.full        (full)
	);

	hcl_fifo #(.W(PAY), .DEPTH(2)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (pay_in),
		.full   (full),
		.pop    (pop),
		.dout   (pay_out),
		.empty  (empty)
	);

	hcl_back #(.CB(CHANNEL_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pay       (pay_out),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

[rtl/hcl_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcl_fifo: short register queue
// Small first-in first-out queue decoupling the front and back halves.
// ----------------------------------------------------------------------------
module hcl_fifo #(
	parameter int W     = 178,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_q];

	// store beat
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue underflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH))
		else $error("queue count out of range");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !empty)
		else $error("queue empty after push");

endmodule

[rtl/hcl_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcl_div: pipelined restoring divider
// One quotient bit per stage; quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module hcl_div #(
	parameter int NW = 16,
	parameter int DW = 8,
	parameter int QW = 8
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	localparam int W = (NW > DW + QW) ? NW : DW + QW;

	logic [W-1:0]  rem_s [QW+1];
	logic [DW-1:0] den_s [QW+1];
	logic [QW-1:0] quo_s [QW+1];

	assign rem_s[0] = W'(num);
	assign den_s[0] = den;
	assign quo_s[0] = '0;
	assign quo      = quo_s[QW];

	// one compare and subtract per stage, highest bit first
	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [W-1:0] trial;
		logic         hit;

		assign trial = W'(den_s[k]) << (QW - 1 - k);
		assign hit   = (rem_s[k] >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= hit ? rem_s[k] - trial : rem_s[k];
				den_s[k+1] <= den_s[k];
				quo_s[k+1] <= {quo_s[k][QW-2:0], hit};
			end
		end
	end

endmodule

[rtl/hcl_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcl_front: input stages
// Splits hue into sector and fraction, clamps the white position and forms
// all numerators and the white divisor over two stages.
// ----------------------------------------------------------------------------
module hcl_front #(
	parameter int CB = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [hcl_pkg::CFG_W-1:0]      cold_kelvin,
	input  logic [hcl_pkg::CFG_W-1:0]      warm_kelvin,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [hcl_pkg::IN_W-1:0]       in_data,
	output logic                           push,
	output logic [hcl_pkg::pay_w(CB)-1:0]  pay,
	input  logic                           full
);

	localparam int MW = CB + 8;

	logic [15:0] hue;
	logic [7:0]  sat;
	logic [7:0]  bri;
	logic [7:0]  lvl;
	logic [15:0] tk;
	logic [18:0] h6;
	logic [15:0] ff;
	logic [24:0] sq;
	logic [24:0] st;
	logic [15:0] diff;
	logic [14:0] rng;
	logic [14:0] pos;
	logic        adv;

	logic                      v_s1, v_s2;
	logic [hcl_pkg::SEC_W-1:0] sec_s1, sec_s2;
	logic                      satz_s1, satz_s2;
	logic                      wen_s1, wen_s2;
	logic [MW-1:0]             mv_s1;
	logic [MW-1:0]             ml_s1;
	logic [23:0]               aq_s1, at_s1;
	logic [7:0]                ps_s1;
	logic [14:0]               pos_s1, neg_s1, rng_s1;
	logic [CB+7:0]             nv_s2;
	logic [CB+15:0]            np_s2, nq_s2, nt_s2;
	logic [CB+22:0]            ncw_s2, nww_s2;
	logic [hcl_pkg::RNG_DW-1:0] dw_s2;
	logic [CB+31:0]            pq, pt;

	assign hue = in_data[15:0];
	assign sat = in_data[23:16];
	assign bri = in_data[31:24];
	assign lvl = in_data[39:32];
	assign tk  = in_data[55:40];

	assign adv      = !v_s2 || !full;
	assign in_ready = adv;
	assign push     = v_s2 && !full;

	// sector and fraction of hue times six, saturation products, white clamp
	always_comb begin
		h6   = ({3'b0, hue} << 2) + ({3'b0, hue} << 1);
		ff   = h6[15:0];
		sq   = 25'(sat) * 25'(ff);
		st   = 25'(sat) * (25'h10000 - 25'(ff));
		rng  = cold_kelvin - warm_kelvin;
		diff = tk - 16'(warm_kelvin);
		if (tk <= 16'(warm_kelvin)) begin
			pos = '0;
		end else if (diff >= 16'(rng)) begin
			pos = rng;
		end else begin
			pos = diff[14:0];
		end
	end

	// stage 1: scaled levels and clamped position
	always_ff @(posedge clk) begin
		if (adv) begin
			sec_s1  <= h6[18:16];
			satz_s1 <= (sat == '0);
			wen_s1  <= (cold_kelvin > warm_kelvin);
			mv_s1   <= ({bri, CB'(0)} - MW'(bri));
			ml_s1   <= ({lvl, CB'(0)} - MW'(lvl));
			aq_s1   <= hcl_pkg::FULL_Q - sq[23:0];
			at_s1   <= hcl_pkg::FULL_Q - st[23:0];
			ps_s1   <= hcl_pkg::UNIT - sat;
			pos_s1  <= pos;
			neg_s1  <= rng - pos;
			rng_s1  <= rng;
		end
	end

	assign pq = (CB+32)'(mv_s1) * (CB+32)'(aq_s1);
	assign pt = (CB+32)'(mv_s1) * (CB+32)'(at_s1);

	// stage 2: numerators; q and t drop the 2^16 of their divisor
	always_ff @(posedge clk) begin
		if (adv) begin
			sec_s2  <= sec_s1;
			satz_s2 <= satz_s1;
			wen_s2  <= wen_s1;
			nv_s2   <= mv_s1;
			np_s2   <= (CB+16)'(mv_s1) * (CB+16)'(ps_s1);
			nq_s2   <= pq[CB+31:16];
			nt_s2   <= pt[CB+31:16];
			ncw_s2  <= (CB+23)'(ml_s1) * (CB+23)'(pos_s1);
			nww_s2  <= (CB+23)'(ml_s1) * (CB+23)'(neg_s1);
			dw_s2   <= ({rng_s1, 8'b0} - 23'(rng_s1));
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	assign pay = {dw_s2, nww_s2, ncw_s2, nt_s2, nq_s2, np_s2, nv_s2,
		wen_s2, satz_s2, sec_s2};

endmodule

[rtl/hcl_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcl_back: divide, select and pack
// Scales v/p/q/t by reciprocal multiplication, runs two pipelined dividers
// for the white channels, picks v/p/q/t per sector and registers the packed
// LED word.
// ----------------------------------------------------------------------------
module hcl_back #(
	parameter int CB = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [hcl_pkg::pay_w(CB)-1:0]  pay,
	input  logic                           empty,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [hcl_pkg::OUT_W-1:0]      out_data
);

	localparam int SW = hcl_pkg::SEC_W + 2 + 4 * CB;
	localparam int PW = 5 * CB;
	// floor(x / d) = (x * ceil(2^s / d)) >> s, exact over the numerator ranges
	localparam int VSH = CB + 16;
	localparam int PSH = CB + 32;
	localparam longint unsigned VREC = ((64'd1 << VSH) + 64'd254) / 64'd255;
	localparam longint unsigned PREC = ((64'd1 << PSH) + 64'd65024) / 64'd65025;

	logic [hcl_pkg::SEC_W-1:0]  sec_in;
	logic                       satz_in, wen_in;
	logic [CB+7:0]              nv;
	logic [CB+15:0]             np, nq, nt;
	logic [CB+22:0]             ncw, nww;
	logic [hcl_pkg::RNG_DW-1:0] dw;
	logic                       adv;

	logic [2*CB+15:0] mv;
	logic [2*CB+31:0] mp, mq, mt;
	logic [CB-1:0] qv0, qp0, qq0, qt0;
	logic [CB-1:0] qv, qp, qq, qt, qcw, qww;
	logic [SW-1:0] side_s [CB+1];
	logic          vld_s  [CB+1];
	logic [hcl_pkg::SEC_W-1:0] sec_d;
	logic          satz_d, wen_d;
	logic [CB-1:0] r, g, b, cw, ww;
	logic [PW+39:0] wide;
	logic          out_valid_q;
	logic [hcl_pkg::OUT_W-1:0] out_data_q;
	hcl_pkg::sector_t sec;

	assign {dw, nww, ncw, nt, nq, np, nv, wen_in, satz_in, sec_in} = pay;

	assign adv = !out_valid_q || out_ready;
	assign pop = adv && !empty;

	// divide v by 255 and p, q, t by 255*255
	assign mv  = (2*CB+16)'(nv) * (2*CB+16)'(VREC);
	assign mp  = (2*CB+32)'(np) * (2*CB+32)'(PREC);
	assign mq  = (2*CB+32)'(nq) * (2*CB+32)'(PREC);
	assign mt  = (2*CB+32)'(nt) * (2*CB+32)'(PREC);
	assign qv0 = mv[2*CB+15:VSH];
	assign qp0 = mp[2*CB+31:PSH];
	assign qq0 = mq[2*CB+31:PSH];
	assign qt0 = mt[2*CB+31:PSH];

	hcl_div #(.NW(CB+23), .DW(hcl_pkg::RNG_DW), .QW(CB)) u_div_cw (
		.clk(clk), .en(adv), .num(ncw), .den(dw), .quo(qcw));
	hcl_div #(.NW(CB+23), .DW(hcl_pkg::RNG_DW), .QW(CB)) u_div_ww (
		.clk(clk), .en(adv), .num(nww), .den(dw), .quo(qww));

	assign side_s[0] = {qt0, qq0, qp0, qv0, wen_in, satz_in, sec_in};
	assign vld_s[0]  = !empty;

	// carry flags and color channels alongside the dividers
	for (genvar k = 0; k < CB; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k+1] <= side_s[k];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	assign {qt, qq, qp, qv, wen_d, satz_d, sec_d} = side_s[CB];
	assign sec = hcl_pkg::sector_t'(sec_d);

	// pick channels per sector; gray at zero saturation, white only if cold > warm
	always_comb begin
		unique case (sec)
			hcl_pkg::SEC_RY: begin r = qv; g = qt; b = qp; end
			hcl_pkg::SEC_YG: begin r = qq; g = qv; b = qp; end
			hcl_pkg::SEC_GC: begin r = qp; g = qv; b = qt; end
			hcl_pkg::SEC_CB: begin r = qp; g = qq; b = qv; end
			hcl_pkg::SEC_BM: begin r = qt; g = qp; b = qv; end
			default:         begin r = qv; g = qp; b = qq; end
		endcase
		if (satz_d) begin
			r = qv;
			g = qv;
			b = qv;
		end
		if (wen_d) begin
			cw = qcw;
			ww = qww;
		end else begin
			cw = '0;
			ww = '0;
		end
		wide = {40'b0, cw, ww, b, r, g};
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= wide[39:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s[CB];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for hsv_cct_to_led_word
// Drives pixels through the stream port with bursty traffic and a randomly
// stalling sink, predicts LED words in integer arithmetic (directed rows may
// give them typed in), and compares each output beat in order. Cold and warm
// LED temperatures are rewritten per phase, including equal, inverted, extreme.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CB = 8;
	localparam longint CMAX = (64'd1 << CB) - 1;
	localparam int LAT = CB + 4;

	typedef struct packed {
		logic [15:0] kelvin;
		logic [7:0]  level;
		logic [7:0]  bright;
		logic [7:0]  sat;
		logic [15:0] hue;
	} pixel_t;

	typedef struct {
		pixel_t pix;
		logic   known;
		logic [39:0] word;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [hcl_pkg::IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [hcl_pkg::OUT_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = hcl_pkg::CFG_COLD;
	logic [hcl_pkg::CFG_W-1:0] cfg_data = '0;

	logic [hcl_pkg::CFG_W-1:0] cold_k = hcl_pkg::COLD_RST;
	logic [hcl_pkg::CFG_W-1:0] warm_k = hcl_pkg::WARM_RST;
	logic [39:0] led_words_due[$];
	int errors = 0;
	int words_seen = 0;
	int hold_off = 0;
	bit sink_free = 1'b0;
	row_t plan[$];
	logic [hcl_pkg::CFG_W-1:0] settings[6][2];

	hsv_cct_to_led_word #(.CHANNEL_BITS(CB)) dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("FAIL hsv_cct_to_led_word");
		$finish;
	end

	// compute the LED word for one pixel at the current temperatures
	function automatic logic [39:0] led_word_of(input pixel_t px);
		longint unsigned h6, ff, den, p, q, t, vch, r, g, b, cw, ww, rng, pos;
		logic [2:0] sector;
		vch = (CMAX * px.bright) / 255;
		cw = 0;
		ww = 0;
		if (px.sat == 0) begin
			r = vch; g = vch; b = vch;
		end else begin
			h6 = px.hue * 6;
			sector = 3'(h6 >> 16);
			ff = h6 & 64'hFFFF;
			den = 64'd255 * 64'd255 * 64'd65536;
			p = (CMAX * px.bright * (255 - px.sat)) / (255 * 255);
			q = (CMAX * px.bright * (255 * 65536 - px.sat * ff)) / den;
			t = (CMAX * px.bright * (255 * 65536 - px.sat * (65536 - ff))) / den;
			case (sector)
				hcl_pkg::SEC_RY: begin r = vch; g = t; b = p; end
				hcl_pkg::SEC_YG: begin r = q; g = vch; b = p; end
				hcl_pkg::SEC_GC: begin r = p; g = vch; b = t; end
				hcl_pkg::SEC_CB: begin r = p; g = q; b = vch; end
				hcl_pkg::SEC_BM: begin r = t; g = p; b = vch; end
				default: begin r = vch; g = p; b = q; end
			endcase
		end
		if (cold_k > warm_k) begin
			rng = cold_k - warm_k;
			if (px.kelvin <= warm_k) pos = 0;
			else if (px.kelvin - warm_k >= rng) pos = rng;
			else pos = px.kelvin - warm_k;
			cw = (CMAX * px.level * pos) / (rng * 255);
			ww = (CMAX * px.level * (rng - pos)) / (rng * 255);
		end
		return {cw[7:0], ww[7:0], b[7:0], r[7:0], g[7:0]};
	endfunction

	function automatic pixel_t rand_pixel();
		pixel_t px;
		px = 56'({$urandom, $urandom});
		case ($urandom_range(0, 7))
			0: px.sat = 0;
			1: px.sat = 8'hFF;
			2: px.bright = 8'hFF;
			default: ;
		endcase
		if ($urandom_range(0, 3) != 0) px.kelvin = 16'($urandom_range(500, 21000));
		return px;
	endfunction

	// send one pixel; queue the predicted word or the typed-in one
	task automatic send_pixel(input pixel_t px, input logic known, input logic [39:0] w);
		s_tdata <= px;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		led_words_due.push_back(known ? w : led_word_of(px));
		@(negedge clk);
	endtask

	task automatic idle_gap();
		s_tvalid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	// wait for every word, then let the pipeline drain
	task automatic drain();
		s_tvalid <= 1'b0;
		while (led_words_due.size() != 0) @(negedge clk);
		repeat (LAT + 2) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [hcl_pkg::CFG_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == hcl_pkg::CFG_COLD) cold_k = val;
		else warm_k = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// random traffic in bursts with gaps
	task automatic random_burst(input int count);
		int left;
		int burst;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 20);
			for (int i = 0; i < burst && left > 0; i++) begin
				send_pixel(rand_pixel(), 1'b0, '0);
				left--;
			end
			if ($urandom_range(0, 2) != 0) idle_gap();
		end
	endtask

	// sink: random stall pattern, with a long hold-off when requested
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else if (sink_free) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	// check each output beat against the oldest expected word
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			words_seen++;
			if (led_words_due.size() == 0) begin
				$display("%0t: unexpected led_word %h", $time, m_tdata);
				errors++;
			end else begin
				if (m_tdata !== led_words_due[0]) begin
					$display("%0t: led_word expected %h actual %h", $time,
						led_words_due[0], m_tdata);
					errors++;
				end
				void'(led_words_due.pop_front());
			end
		end
	end

	initial begin
		settings = '{
			'{15'd20000, 15'd1000}, '{15'd1000, 15'd20000}, '{15'd5000, 15'd5000},
			'{15'h7FFF, 15'd0}, '{15'd4000, 15'd3999}, '{15'd6500, 15'd2700}};

		// directed rows: typed-in words where they are obvious
		plan = '{
			'{'{16'd0, 8'd0, 8'd0, 8'd0, 16'd0}, 1'b1, 40'h00_00_00_00_00},
			'{'{16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF}, 1'b1, 40'hFF_00_00_FF_00},
			'{'{16'd6500, 8'hFF, 8'd0, 8'hFF, 16'h1234}, 1'b1, 40'hFF_00_00_00_00},
			'{'{16'd2700, 8'hFF, 8'hFF, 8'hFF, 16'd0}, 1'b1, 40'h00_FF_00_FF_00},
			'{'{16'd4600, 8'd0, 8'hFF, 8'd0, 16'd0}, 1'b1, 40'h00_00_FF_FF_FF},
			'{'{16'd2700, 8'd0, 8'hFF, 8'hFF, 16'd10923}, 1'b0, '0},
			'{'{16'd2700, 8'd0, 8'hFF, 8'hFF, 16'd21845}, 1'b0, '0},
			'{'{16'd2700, 8'd0, 8'hFF, 8'hFF, 16'd32768}, 1'b0, '0},
			'{'{16'd2700, 8'd0, 8'hFF, 8'hFF, 16'd43691}, 1'b0, '0},
			'{'{16'd2700, 8'd0, 8'hFF, 8'hFF, 16'd54613}, 1'b0, '0},
			'{'{16'd4000, 8'd128, 8'd200, 8'd77, 16'd10922}, 1'b0, '0},
			'{'{16'd6501, 8'd1, 8'd1, 8'd1, 16'd65535}, 1'b0, '0},
			'{'{16'd4600, 8'd200, 8'd255, 8'd128, 16'd8000}, 1'b0, '0},
			'{'{16'hAAAA, 8'h55, 8'hAA, 8'h55, 16'h5555}, 1'b0, '0},
			'{'{16'h5555, 8'hAA, 8'h55, 8'hAA, 16'hAAAA}, 1'b0, '0}};

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part at reset temperatures
		foreach (plan[i]) begin
			send_pixel(plan[i].pix, plan[i].known, plan[i].word);
			if ($urandom_range(0, 2) == 0) idle_gap();
		end
		drain();

		// long sink hold-off while the source keeps pushing
		hold_off = 60;
		random_burst(40);
		drain();

		// one phase per temperature setting
		foreach (settings[k]) begin
			write_reg(hcl_pkg::CFG_COLD, settings[k][0]);
			write_reg(hcl_pkg::CFG_WARM, settings[k][1]);
			sink_free = (k == 2);
			random_burst(240);
			drain();
		end

		$display("covered %0d LED words over 7 temperature settings, with", words_seen);
		$display("gray, sector, clamp and no-white-range cases plus stalls");
		if (errors == 0) begin
			$display("PASS hsv_cct_to_led_word");
		end else begin
			$display("FAIL hsv_cct_to_led_word");
		end
		$finish;
	end

endmodule

[hsv_cct_to_led_word.f]
rtl/hcl_pkg.sv
rtl/hcl_fifo.sv
rtl/hcl_div.sv
rtl/hcl_front.sv
rtl/hcl_back.sv
rtl/hsv_cct_to_led_word.sv
sim/testbench.sv
